// ===== rtl/tsb_pkg.sv =====
// shared types, constants and operation codes of the timer slot bank
package tsb_pkg;

    // field widths of the request and response beats
    localparam int OP_W    = 3;
    localparam int SLOT_W  = 3;
    localparam int TICK_W  = 16;
    localparam int FIRE_W  = 8;

    // largest bank the slot field and fire mask can address
    localparam int BANK_MAX      = 8;
    localparam int SLOTS_DEFAULT = 8;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 3'd0,
        OP_DESTROY = 3'd1,
        OP_START   = 3'd2,
        OP_STOP    = 3'd3,
        OP_TICK    = 3'd4
    } tsb_op_t;

    // command from the sequencer to the slot table
    typedef struct packed {
        logic              create;
        logic              destroy;
        logic              start;
        logic              stop;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] period;
    } tsb_cmd_t;

    // allocation status from the slot table
    typedef struct packed {
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
    } tsb_stat_t;

endpackage

// ===== rtl/tsb_if.sv =====
// valid/ready channel interfaces for the request and response beats
interface tsb_req_if;
    import tsb_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] period;

    modport source (output valid, output op, output slot, output period, input ready);
    modport sink   (input valid, input op, input slot, input period, output ready);
endinterface

interface tsb_rsp_if;
    import tsb_pkg::*;

    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] granted_slot;
    logic              granted;
    logic [FIRE_W-1:0] fire_mask;
    logic [TICK_W-1:0] tick_count;

    modport source (output valid, output granted_slot, output granted, output fire_mask,
                    output tick_count, input ready);
    modport sink   (input valid, input granted_slot, input granted, input fire_mask,
                    input tick_count, output ready);
endinterface

// ===== rtl/tsb_rem_serial.sv =====
// bit-serial restoring remainder unit, one quotient bit per cycle
module tsb_rem_serial
    import tsb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TICK_W-1:0] dividend,
    input  logic [TICK_W-1:0] divisor,
    output logic              done,
    output logic              rem_zero
);

    localparam int CNT_W = $clog2(TICK_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TICK_W-1:0] dvd_reg, dvd_next;
    logic [TICK_W-1:0] div_reg, div_next;
    logic [TICK_W-1:0] rem_reg, rem_next;

    logic [TICK_W:0]   rem_shift;
    logic [TICK_W:0]   rem_sub;
    logic              ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[TICK_W-1]};
        rem_sub   = rem_shift - {1'b0, div_reg};
        ge        = (rem_shift >= {1'b0, div_reg});
    end

    // step control
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(TICK_W);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[TICK_W-2:0], 1'b0};
            rem_next = ge ? rem_sub[TICK_W-1:0] : rem_shift[TICK_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

// ===== rtl/tsb_slot_table.sv =====
// slot table: allocation flags, stopped flags and stored periods
module tsb_slot_table
    import tsb_pkg::*;
#(
    parameter int ACTIVE = BANK_MAX
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tsb_cmd_t                     cmd,
    output tsb_stat_t                    stat,
    input  logic [$clog2(ACTIVE+1)-1:0]  rd_idx,
    output logic [TICK_W-1:0]            rd_period,
    output logic                         rd_live
);

    localparam int IDX_W = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
    localparam int RD_W  = $clog2(ACTIVE + 1);

    logic [ACTIVE-1:0] in_use_reg, in_use_next;
    logic [ACTIVE-1:0] stopped_reg, stopped_next;
    logic [TICK_W-1:0] period_reg [ACTIVE];

    logic              slot_ok;
    logic [IDX_W-1:0]  slot_idx;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  rd_sel;

    // lowest free slot
    always_comb
    begin
        stat.free_found = 1'b0;
        stat.free_slot  = '0;
        free_idx        = '0;
        for (int i = ACTIVE - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                stat.free_found = 1'b1;
                stat.free_slot  = SLOT_W'(i);
                free_idx        = IDX_W'(i);
            end
        end
    end

    // targeted slot, ignored beyond the bank
    assign slot_ok  = ({1'b0, cmd.slot} < (SLOT_W+1)'(ACTIVE));
    assign slot_idx = cmd.slot[IDX_W-1:0];

    // flag updates
    always_comb
    begin
        in_use_next  = in_use_reg;
        stopped_next = stopped_reg;
        if (cmd.create && stat.free_found)
        begin
            in_use_next[free_idx]  = 1'b1;
            stopped_next[free_idx] = 1'b1;
        end
        if (cmd.destroy && slot_ok)
        begin
            in_use_next[slot_idx] = 1'b0;
        end
        if (cmd.start && slot_ok)
        begin
            stopped_next[slot_idx] = 1'b0;
        end
        if (cmd.stop && slot_ok)
        begin
            stopped_next[slot_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg  <= '0;
            stopped_reg <= '0;
        end
        else
        begin
            in_use_reg  <= in_use_next;
            stopped_reg <= stopped_next;
        end
    end

    // period store, written on create
    always_ff @(posedge clk)
    begin
        if (cmd.create && stat.free_found)
        begin
            period_reg[free_idx] <= cmd.period;
        end
    end

    // scan read port
    assign rd_sel    = rd_idx[IDX_W-1:0];
    assign rd_period = period_reg[rd_sel];
    assign rd_live   = in_use_reg[rd_sel] && !stopped_reg[rd_sel] && (rd_idx < RD_W'(ACTIVE));

endmodule

// ===== rtl/periodic_timer_slot_bank.sv =====
// top level of the periodic timer slot bank: sequencer and result register
// A bank of up to eight timer slots driven by one request beat per operation:
// create, destroy, start, stop and tick. Every request yields exactly one
// response beat. Create, destroy, start, stop and unknown ops go from
// acceptance through the done state into the response register. A tick
// advances the 16-bit count and then scans the slots one after another
// through a single bit-serial remainder unit, each slot with one load,
// sixteen shift-subtract steps and one check. One request is in work at a
// time; the response register holds the last result while the next request
// is accepted.
module periodic_timer_slot_bank
    import tsb_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    tsb_req_if.sink   req,
    tsb_rsp_if.source rsp
);

    localparam int ACTIVE = (SLOTS < BANK_MAX) ? SLOTS : BANK_MAX;
    localparam int K_W    = $clog2(ACTIVE + 1);
    localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_WAIT = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [ACTIVE-1:0] fire_reg, fire_next;
    logic [SLOT_W-1:0] gslot_reg, gslot_next;
    logic              gok_reg, gok_next;

    logic              out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0] out_gslot_reg, out_gslot_next;
    logic              out_gok_reg, out_gok_next;
    logic [FIRE_W-1:0] out_fire_reg, out_fire_next;
    logic [TICK_W-1:0] out_tick_reg, out_tick_next;

    logic              acc;
    logic              out_load;
    tsb_cmd_t          cmd;
    tsb_stat_t         stat;
    logic [TICK_W-1:0] rd_period;
    logic              rd_live;
    logic              rem_start;
    logic              rem_done;
    logic              rem_zero;

    assign req.ready = (state_reg == S_IDLE);
    assign acc       = req.valid && req.ready;

    // decode the request beat into table commands
    always_comb
    begin
        cmd.create  = acc && (req.op == OP_CREATE);
        cmd.destroy = acc && (req.op == OP_DESTROY);
        cmd.start   = acc && (req.op == OP_START);
        cmd.stop    = acc && (req.op == OP_STOP);
        cmd.slot    = req.slot;
        cmd.period  = req.period;
    end

    tsb_slot_table #(
        .ACTIVE (ACTIVE)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .rd_idx    (k_reg),
        .rd_period (rd_period),
        .rd_live   (rd_live)
    );

    assign rem_start = (state_reg == S_LOAD);

    tsb_rem_serial u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (elapsed_reg),
        .divisor  (rd_period),
        .done     (rem_done),
        .rem_zero (rem_zero)
    );

    // response register can take a new result
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        k_next       = k_reg;
        fire_next    = fire_reg;
        gslot_next   = gslot_reg;
        gok_next     = gok_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    fire_next  = '0;
                    gok_next   = cmd.create && stat.free_found;
                    gslot_next = (cmd.create && stat.free_found) ? stat.free_slot : '0;
                    k_next     = '0;
                    if (req.op == OP_TICK)
                    begin
                        elapsed_next = elapsed_reg + TICK_W'(1);
                        state_next   = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (rem_done)
                begin
                    if (rd_live && (rd_period != '0) && rem_zero)
                    begin
                        fire_next[k_reg[IDX_W-1:0]] = 1'b1;
                    end
                    if (k_reg == K_W'(ACTIVE - 1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + K_W'(1);
                        state_next = S_LOAD;
                    end
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // response register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_gslot_next = out_gslot_reg;
        out_gok_next   = out_gok_reg;
        out_fire_next  = out_fire_reg;
        out_tick_next  = out_tick_reg;
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_gslot_next = gslot_reg;
            out_gok_next   = gok_reg;
            out_fire_next  = FIRE_W'(fire_reg);
            out_tick_next  = elapsed_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        fire_reg      <= fire_next;
        gslot_reg     <= gslot_next;
        gok_reg       <= gok_next;
        out_gslot_reg <= out_gslot_next;
        out_gok_reg   <= out_gok_next;
        out_fire_reg  <= out_fire_next;
        out_tick_reg  <= out_tick_next;
    end

    // response beat
    assign rsp.valid        = out_valid_reg;
    assign rsp.granted_slot = out_gslot_reg;
    assign rsp.granted      = out_gok_reg;
    assign rsp.fire_mask    = out_fire_reg;
    assign rsp.tick_count   = out_tick_reg;

endmodule

// ===== tb/periodic_timer_slot_bank_test.sv =====
// self-checking testbench for the periodic timer slot bank: directed table, random ops, stalls
module periodic_timer_slot_bank_test
    import tsb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // slots the bank really has, and the op codes the block treats as no-ops
    localparam int LIVE_SLOTS = (SLOTS_DEFAULT < BANK_MAX) ? SLOTS_DEFAULT : BANK_MAX;
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam int RANDOM_OPS = 1725;
    localparam int MAX_WAIT   = 12;
    localparam int HOLD_OFF   = 400;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_WAIT = 200;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        logic              granted;
        logic [FIRE_W-1:0] fire_mask;
        logic [TICK_W-1:0] tick_count;
    } slot_result_t;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] period;
        bit                typed;
        slot_result_t      answer;
    } plan_row_t;

    typedef struct {
        bit           typed;
        slot_result_t answer;
    } typed_answer_t;

    logic clk = 1'b0;
    logic rst_n;

    tsb_req_if req_bus ();
    tsb_rsp_if rsp_bus ();

    periodic_timer_slot_bank dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted bank state
    logic [LIVE_SLOTS-1:0] bank_in_use = '0;
    logic [LIVE_SLOTS-1:0] bank_halted = '0;
    logic [TICK_W-1:0]     bank_period [LIVE_SLOTS];
    logic [TICK_W-1:0]     ms_count = '0;

    plan_row_t     directed_plan [$];
    typed_answer_t typed_answers [$];
    slot_result_t  awaited_results [$];

    int error_count = 0;
    int idle_cycles = 0;
    int req_beats   = 0;
    int rsp_beats   = 0;
    int tick_beats  = 0;
    int fire_beats  = 0;
    int grant_beats = 0;
    int full_beats  = 0;
    bit send_idle   = 1'b1;
    bit take_idle   = 1'b1;

    // one line per failure, counted
    task automatic flag_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // apply one op to the predicted bank and return the beat it should produce
    function automatic slot_result_t predict_outcome(input logic [OP_W-1:0] op,
                                                     input logic [SLOT_W-1:0] slot,
                                                     input logic [TICK_W-1:0] period);
        slot_result_t res;
        bit           found;
        res   = '0;
        found = 1'b0;
        case (op)
            OP_CREATE:
            begin
                for (int i = 0; i < LIVE_SLOTS; i++)
                begin
                    if (!found && !bank_in_use[i])
                    begin
                        bank_period[i]   = period;
                        bank_halted[i]   = 1'b1;
                        bank_in_use[i]   = 1'b1;
                        res.granted_slot = SLOT_W'(i);
                        res.granted      = 1'b1;
                        found            = 1'b1;
                    end
                end
            end
            OP_DESTROY:
                if (slot < LIVE_SLOTS)
                    bank_in_use[slot] = 1'b0;
            OP_START:
                if (slot < LIVE_SLOTS)
                    bank_halted[slot] = 1'b0;
            OP_STOP:
                if (slot < LIVE_SLOTS)
                    bank_halted[slot] = 1'b1;
            OP_TICK:
            begin
                ms_count = ms_count + 1'b1;
                for (int i = 0; i < LIVE_SLOTS; i++)
                begin
                    if (bank_in_use[i] && !bank_halted[i] && bank_period[i] != '0 &&
                        (ms_count % bank_period[i]) == '0)
                        res.fire_mask[i] = 1'b1;
                end
            end
            default: ;
        endcase
        res.tick_count = ms_count;
        return res;
    endfunction

    // one row of the directed table; typed rows carry their answer
    task automatic add_row(input logic [OP_W-1:0] op, input int slot, input int period,
                           input bit typed, input int gslot, input int gok, input int fire,
                           input int ticks);
        plan_row_t row;
        row.op     = op;
        row.slot   = SLOT_W'(slot);
        row.period = TICK_W'(period);
        row.typed  = typed;
        row.answer = {SLOT_W'(gslot), 1'(gok), FIRE_W'(fire), TICK_W'(ticks)};
        directed_plan.push_back(row);
    endtask

    // offer one request beat after a drawn gap and hold it until taken
    task automatic offer_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                                 input logic [TICK_W-1:0] period, input bit typed,
                                 input slot_result_t answer);
        int            gap;
        typed_answer_t pin;
        if ($urandom_range(0, 39) == 0)
            send_idle = !send_idle;
        gap = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pin.typed  = typed;
        pin.answer = answer;
        typed_answers.push_back(pin);
        req_bus.valid  <= 1'b1;
        req_bus.op     <= op;
        req_bus.slot   <= slot;
        req_bus.period <= period;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
    endtask

    // response side: random stalls, plus one long hold-off to back up the block
    initial
    begin
        int  gap;
        int  taken;
        bit  pressed;
        taken   = 0;
        pressed = 1'b0;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                take_idle = !take_idle;
            if (!pressed && taken >= 150)
            begin
                pressed = 1'b1;
                gap     = HOLD_OFF;
            end
            else
                gap = take_idle ? $urandom_range(0, MAX_WAIT) : 0;
            if (gap != 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_bus.valid)
                @(posedge clk);
            taken++;
        end
    end

    // beat monitor: check responses, predict accepted requests, watchdog
    always @(posedge clk)
    begin
        slot_result_t  got;
        slot_result_t  want;
        slot_result_t  calc;
        typed_answer_t pin;
        bit            moved;
        moved = 1'b0;
        if (rst_n)
        begin
            // response beat against the oldest expectation
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                moved = 1'b1;
                rsp_beats++;
                got = {rsp_bus.granted_slot, rsp_bus.granted, rsp_bus.fire_mask,
                       rsp_bus.tick_count};
                if (awaited_results.size() == 0)
                    flag_error($sformatf("response beat %0d with nothing outstanding", rsp_beats));
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.granted_slot !== want.granted_slot)
                        flag_error($sformatf("beat %0d granted_slot %0d, expected %0d",
                                             rsp_beats, got.granted_slot, want.granted_slot));
                    if (got.granted !== want.granted)
                        flag_error($sformatf("beat %0d granted %0b, expected %0b",
                                             rsp_beats, got.granted, want.granted));
                    if (got.fire_mask !== want.fire_mask)
                        flag_error($sformatf("beat %0d fire_mask %h, expected %h",
                                             rsp_beats, got.fire_mask, want.fire_mask));
                    if (got.tick_count !== want.tick_count)
                        flag_error($sformatf("beat %0d tick_count %0d, expected %0d",
                                             rsp_beats, got.tick_count, want.tick_count));
                end
            end
            // request beat: advance the predicted bank
            if (req_bus.valid && req_bus.ready)
            begin
                moved = 1'b1;
                req_beats++;
                calc = predict_outcome(req_bus.op, req_bus.slot, req_bus.period);
                pin  = typed_answers.pop_front();
                awaited_results.push_back(pin.typed ? pin.answer : calc);
                if (req_bus.op == OP_TICK)
                begin
                    tick_beats++;
                    if (calc.fire_mask != '0)
                        fire_beats++;
                end
                if (req_bus.op == OP_CREATE)
                begin
                    if (calc.granted)
                        grant_beats++;
                    else
                        full_beats++;
                end
            end
        end
        if (moved)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[%0t] no beat for %0d cycles", $realtime, IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int           pick;
        int           reach;
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] period;
        rst_n          <= 1'b0;
        req_bus.valid  <= 1'b0;
        req_bus.op     <= OP_CREATE;
        req_bus.slot   <= '0;
        req_bus.period <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: op, slot, period, typed, granted_slot, granted, fire, tick_count
        add_row(OP_TICK,    0, 0,      1, 0, 0, 0, 1);   // empty bank ticks without firing
        add_row(OP_RSVD5,   7, 'hFFFF, 1, 0, 0, 0, 1);   // unknown ops change nothing
        add_row(OP_RSVD6,   5, 'h5555, 1, 0, 0, 0, 1);
        add_row(OP_RSVD7,   0, 0,      1, 0, 0, 0, 1);
        add_row(OP_CREATE,  0, 1,      1, 0, 1, 0, 1);   // fill the bank lowest slot first
        add_row(OP_CREATE,  5, 0,      1, 1, 1, 0, 1);
        add_row(OP_CREATE,  7, 'hFFFF, 1, 2, 1, 0, 1);
        add_row(OP_CREATE,  0, 2,      1, 3, 1, 0, 1);
        add_row(OP_CREATE,  0, 3,      1, 4, 1, 0, 1);
        add_row(OP_CREATE,  0, 4,      1, 5, 1, 0, 1);
        add_row(OP_CREATE,  0, 5,      1, 6, 1, 0, 1);
        add_row(OP_CREATE,  0, 'h8000, 1, 7, 1, 0, 1);
        add_row(OP_CREATE,  0, 7,      1, 0, 0, 0, 1);   // bank full: refused
        add_row(OP_TICK,    0, 0,      1, 0, 0, 0, 2);   // all slots still stopped
        add_row(OP_START,   0, 0,      0, 0, 0, 0, 0);
        add_row(OP_START,   1, 0,      0, 0, 0, 0, 0);   // zero period, never fires
        add_row(OP_START,   2, 0,      0, 0, 0, 0, 0);
        add_row(OP_START,   3, 0,      0, 0, 0, 0, 0);
        add_row(OP_START,   7, 0,      0, 0, 0, 0, 0);
        add_row(OP_TICK,    0, 0,      0, 0, 0, 0, 0);
        add_row(OP_STOP,    0, 0,      0, 0, 0, 0, 0);
        add_row(OP_DESTROY, 3, 0,      0, 0, 0, 0, 0);
        add_row(OP_TICK,    0, 0,      0, 0, 0, 0, 0);
        add_row(OP_DESTROY, 3, 0,      0, 0, 0, 0, 0);   // already free
        add_row(OP_START,   3, 0,      0, 0, 0, 0, 0);   // start on a free slot
        add_row(OP_CREATE,  0, 6,      0, 0, 0, 0, 0);   // refills the freed slot, stopped

        foreach (directed_plan[k])
            offer_request(directed_plan[k].op, directed_plan[k].slot, directed_plan[k].period,
                          directed_plan[k].typed, directed_plan[k].answer);

        // random ops, weighted toward ticks and bank churn, periods mostly short
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
                op = OP_CREATE;
            else if (pick < 28)
                op = OP_DESTROY;
            else if (pick < 46)
                op = OP_START;
            else if (pick < 56)
                op = OP_STOP;
            else if (pick < 95)
                op = OP_TICK;
            else
                op = OP_RSVD5 + OP_W'($urandom_range(0, 2));
            slot  = SLOT_W'($urandom_range(0, 7));
            reach = $urandom_range(0, 9);
            if (reach < 7)
                period = TICK_W'($urandom_range(1, 12));
            else if (reach == 7)
                period = '0;
            else if (reach == 8)
                period = TICK_W'($urandom_range(13, 1000));
            else
                period = TICK_W'($urandom);
            offer_request(op, slot, period, 1'b0, '0);
        end
        req_bus.valid <= 1'b0;

        // drain, then give any stray beat time to show up
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (awaited_results.size() != 0)
            flag_error($sformatf("%0d responses never arrived", awaited_results.size()));

        $display("run: %0d request beats, %0d ticks (%0d firing), count reached %0d",
                 req_beats, tick_beats, fire_beats, ms_count);
        $display("run: %0d slots granted, %0d creates refused on a full bank, %0d errors",
                 grant_beats, full_beats, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tsb_pkg.sv
rtl/tsb_if.sv
rtl/tsb_rem_serial.sv
rtl/tsb_slot_table.sv
rtl/periodic_timer_slot_bank.sv
tb/periodic_timer_slot_bank_test.sv
